// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the date and weekday unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ndw_pkg.sv =====
// ----------------------------------------------------------------------------
// ndw_pkg
// Types, constants and month tables of the next date and weekday unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ndw_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int WDAY_W  = 3;

   // Documented upper end of the year range.
   localparam int YEAR_MAX = 9999;

   localparam int GREG_START = 1600;
   localparam int CENTURY    = 100;

   // year / 100 == (year * 5243) >> 19, exact for all 14-bit years.
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV100_PW    = YEAR_W + 13;
   localparam int QUOT_W       = 8;

   // sum / 7 == (sum * 147) >> 10, exact for sums up to 203.
   localparam int DIV7_MUL   = 147;
   localparam int DIV7_SHIFT = 10;
   localparam int WEEK       = 7;
   localparam int SUM_W      = 8;
   localparam int DIV7_PW    = 2 * SUM_W;

   // Clock edges from the edge that takes a word to the edge that takes its result.
   localparam int LATENCY = 4;

   localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } req_type;

   typedef struct packed {
      logic [DAY_W-1:0]   next_day;
      logic [MONTH_W-1:0] next_month;
      logic [YEAR_W-1:0]  next_year;
      logic [WDAY_W-1:0]  weekday;
      logic               leap_year;
      logic [DAY_W-1:0]   month_length;
      logic               range_error;
   } rsp_type;

   // Calendar results of the middle stage, weekday still as an unreduced sum.
   typedef struct packed {
      logic [DAY_W-1:0]   next_day;
      logic [MONTH_W-1:0] next_month;
      logic [YEAR_W-1:0]  next_year;
      logic               leap_year;
      logic [DAY_W-1:0]   month_length;
      logic               range_error;
      logic [SUM_W-1:0]   weekday_sum;
   } cal_type;

   // Days of a common year's month; codes that are no month count 31.
   function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] d;
      case (m)
         4'd2:    d = 5'd28;
         4'd4:    d = 5'd30;
         4'd6:    d = 5'd30;
         4'd9:    d = 5'd30;
         4'd11:   d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

   // Weekday offset of a month in a common year; codes that are no month give 0.
   function automatic logic [WDAY_W-1:0] month_code(input logic [MONTH_W-1:0] m);
      logic [WDAY_W-1:0] c;
      case (m)
         4'd2:    c = 3'd3;
         4'd3:    c = 3'd3;
         4'd4:    c = 3'd6;
         4'd5:    c = 3'd1;
         4'd6:    c = 3'd4;
         4'd7:    c = 3'd6;
         4'd8:    c = 3'd2;
         4'd9:    c = 3'd5;
         4'd11:   c = 3'd3;
         4'd12:   c = 3'd5;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ndw_date.sv =====
// ----------------------------------------------------------------------------
// ndw_date
// Leap flag, month length, following date and raw weekday sum of one date.
// ----------------------------------------------------------------------------
`default_nettype none

module ndw_date (
   input  ndw_pkg::req_type               req,
   input  logic [ndw_pkg::QUOT_W-1:0]     cent,
   output ndw_pkg::cal_type               cal
);
   import ndw_pkg::*;

   logic [YEAR_W-1:0]  rem_full;
   logic [6:0]         yy;
   logic               leap;
   logic [DAY_W-1:0]   mlen;
   logic [WDAY_W-1:0]  mcode;
   logic [WDAY_W-1:0]  ccode;

   // yy = year mod 100, from the quotient of the previous stage.
   assign rem_full = req.year - YEAR_W'(cent) * YEAR_W'(CENTURY);
   assign yy       = rem_full[6:0];

   // Divisible by 4, and when a century year also by 400.
   assign leap = (req.year[1:0] == 2'b00) && ((yy != 7'd0) || (cent[1:0] == 2'b00));

   // Century code 6,4,2,0 repeats every 400 years; 1600 is a multiple of 400.
   assign ccode = 3'd6 - {cent[1:0], 1'b0};

   always_comb begin
      mlen  = days_in_month(req.month);
      mcode = month_code(req.month);
      if (leap && (req.month == FEBRUARY)) begin
         mlen = 5'd29;
      end
      if (leap && (req.month == JANUARY)) begin
         mcode = 3'd6;
      end else if (leap && (req.month == FEBRUARY)) begin
         mcode = 3'd2;
      end

      cal.next_year = req.year;
      if (req.day >= mlen) begin
         cal.next_day = 5'd1;
         if (req.month == DECEMBER) begin
            cal.next_month = JANUARY;
            cal.next_year  = req.year + 14'd1;
         end else begin
            cal.next_month = req.month + 4'd1;
         end
      end else begin
         cal.next_day   = req.day + 5'd1;
         cal.next_month = req.month;
      end

      cal.leap_year    = leap;
      cal.month_length = mlen;
      cal.range_error  = (req.year < YEAR_W'(GREG_START));
      cal.weekday_sum  = SUM_W'(req.day) + SUM_W'(mcode) + SUM_W'(ccode)
                       + SUM_W'(yy) + SUM_W'(yy[6:2]);
   end

endmodule

`default_nettype wire

// ===== rtl/next_date_and_weekday_unit.sv =====
// ----------------------------------------------------------------------------
// next_date_and_weekday_unit
// Following Gregorian date, weekday, leap flag and month length of a date.
// ----------------------------------------------------------------------------
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_payload       in         start && !busy
//   response  rsp_valid, rsp_payload         out        rsp_valid, one cycle
//
// One word is accepted in every cycle; busy is held low.
// A word passes four registers in order: input register, century quotient,
// calendar logic, weekday reduction. Its result is strobed from the last one.
// The response cannot be stalled, so the pipeline never holds.
// Synchronous reset clears the stage valid flags; words in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module next_date_and_weekday_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ndw_pkg::req_type  req_payload,
   output logic              rsp_valid,
   output ndw_pkg::rsp_type  rsp_payload
);
   import ndw_pkg::*;

   // Stage A: the accepted word.
   logic                    a_valid_ff;
   req_type                 a_req_ff;

   // Stage B: the word and its year divided by one hundred.
   logic                    b_valid_ff;
   req_type                 b_req_ff;
   logic [QUOT_W-1:0]       b_cent_ff;
   logic [DIV100_PW-1:0]    b_prod;
   logic [QUOT_W-1:0]       b_cent_in;

   // Stage C: calendar results and the unreduced weekday sum.
   logic                    c_valid_ff;
   cal_type                 c_cal_ff;
   cal_type                 c_cal_in;

   // Stage D: the sum reduced modulo seven, the registered response.
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic [DIV7_PW-1:0]      d_prod;
   logic [SUM_W-1:0]        d_rem;

   // There is no backpressure anywhere, so a word is taken in every cycle.
   assign busy = 1'b0;

   // The century quotient by multiplication with a scaled reciprocal.
   assign b_prod    = DIV100_PW'(a_req_ff.year) * DIV100_PW'(DIV100_MUL);
   assign b_cent_in = b_prod[DIV100_SHIFT +: QUOT_W];

   ndw_date u_date (
      .req  (b_req_ff),
      .cent (b_cent_ff),
      .cal  (c_cal_in)
   );

   // The weekday is the remainder of the sum after removing whole weeks.
   assign d_prod = DIV7_PW'(c_cal_ff.weekday_sum) * DIV7_PW'(DIV7_MUL);
   assign d_rem  = c_cal_ff.weekday_sum
                 - SUM_W'(d_prod[DIV7_PW-1:DIV7_SHIFT]) * SUM_W'(WEEK);

   always_comb begin
      rsp_in.next_day     = c_cal_ff.next_day;
      rsp_in.next_month   = c_cal_ff.next_month;
      rsp_in.next_year    = c_cal_ff.next_year;
      rsp_in.leap_year    = c_cal_ff.leap_year;
      rsp_in.month_length = c_cal_ff.month_length;
      rsp_in.range_error  = c_cal_ff.range_error;
      // Before the Gregorian start the weekday is reported as zero.
      rsp_in.weekday      = c_cal_ff.range_error ? 3'd0 : d_rem[WDAY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= start && !busy;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
      end
   end

   // Payload registers carry no reset; only the valid flags qualify them.
   always_ff @(posedge clock) begin
      a_req_ff  <= req_payload;
      b_req_ff  <= a_req_ff;
      b_cent_ff <= b_cent_in;
      c_cal_ff  <= c_cal_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/ndw_checker.sv =====
// ----------------------------------------------------------------------------
// ndw_checker
// Port-level checks of the next date and weekday unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ndw_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  ndw_pkg::req_type  req_payload,
   input  logic              rsp_valid,
   input  ndw_pkg::rsp_type  rsp_payload
);
   import ndw_pkg::*;

   logic [LATENCY-1:0]        took_hist_ff;
   logic [LATENCY-1:0]        reset_hist_ff;
   logic [LATENCY*YEAR_W-1:0] year_hist_ff;
   logic                      took_word;
   logic                      reset_seen;
   logic [YEAR_W-1:0]         year_then;
   logic                      range_flagged;
   logic                      wday_cleared;
   logic                      year_checked;
   logic                      year_stepped;
   logic                      mlen_legal;

   // Handshake, reset and year histories, one stage per edge of latency.
   always_ff @(posedge clock) begin
      took_hist_ff  <= {took_hist_ff[LATENCY-2:0], start && !busy};
      reset_hist_ff <= {reset_hist_ff[LATENCY-2:0], reset};
      year_hist_ff  <= {year_hist_ff[(LATENCY-1)*YEAR_W-1:0], req_payload.year};
   end

   assign took_word     = took_hist_ff[LATENCY-1];
   assign reset_seen    = |reset_hist_ff;
   assign year_then     = year_hist_ff[LATENCY*YEAR_W-1 -: YEAR_W];
   assign range_flagged = rsp_valid && rsp_payload.range_error;
   assign wday_cleared  = (rsp_payload.weekday == 3'd0);
   assign year_checked  = rsp_valid && (year_then <= YEAR_W'(YEAR_MAX));
   assign year_stepped  = (rsp_payload.next_year == year_then)
                       || (rsp_payload.next_year == year_then + 14'd1);
   assign mlen_legal    = (rsp_payload.month_length >= 5'd28)
                       && (rsp_payload.month_length <= 5'd31);

   // A strobe only ever answers a word taken a fixed number of cycles before.
   `ASSERT_IMPLIES(a_no_spurious, clock, reset, rsp_valid, took_word, "unexpected result strobe")

   // Every accepted word is answered unless a reset intervened.
   `ASSERT_IMPLIES(a_no_loss, clock, reset, took_word && !reset_seen, rsp_valid, "result lost")

   // The weekday is forced to Sunday for years before the Gregorian start.
   `ASSERT_IMPLIES(a_range_wday, clock, reset, range_flagged, wday_cleared, "weekday not cleared")

   // Within the documented range the year stays or advances by exactly one.
   `ASSERT_IMPLIES(a_year_step, clock, reset, year_checked, year_stepped, "next year skipped")

   // A month has between 28 and 31 days.
   `ASSERT_IMPLIES(a_mlen_range, clock, reset, rsp_valid, mlen_legal, "month length out of range")

endmodule

bind next_date_and_weekday_unit ndw_checker u_ndw_checker (.*);

`default_nettype wire
